>>> src/rmth_pkg.sv
// Shared types and constants for the running median unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package rmth_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 11;
    localparam int OUT_DATA_W = 48;

    typedef logic signed [SAMPLE_W-1:0] t_value;
    typedef logic signed [MEDIAN_W-1:0] t_median;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INS,
        OP_POP
    } t_op;

    typedef struct packed {
        t_op    op;
        t_value value;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWAP,
        ST_PLACE,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

>>> src/rmth_cell.sv
// One slot of a sorted chain: holds a value and shifts or inserts with its neighbors.
// Depends on rmth_pkg.
`default_nettype none

module rmth_cell
    import rmth_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int FW     = 10,
    parameter bit IS_MAX = 1'b0
) (
    input  wire logic          i_clk,
    input  wire t_cell_cmd     i_cmd,
    input  wire logic [FW-1:0] i_fill,
    input  wire t_value        i_prev_val,
    input  wire logic          i_prev_before,
    input  wire t_value        i_next_val,
    output t_value             o_val,
    output logic               o_before
);

    t_value r_val;
    t_value n_val;
    logic   w_used;
    logic   w_at_end;
    logic   w_ranks;

    assign w_used   = FW'(IDX) < i_fill;
    assign w_at_end = FW'(IDX) == i_fill;
    assign w_ranks  = IS_MAX ? (i_cmd.value > r_val) : (i_cmd.value < r_val);
    assign o_before = w_used && w_ranks;
    assign o_val    = r_val;

    always_comb begin
        n_val = r_val;
        case (i_cmd.op)
            OP_INS: begin
                if (i_prev_before) begin
                    n_val = i_prev_val;
                end else if (o_before || w_at_end) begin
                    n_val = i_cmd.value;
                end
            end
            OP_POP:  n_val = i_next_val;
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

>>> src/rmth_chain.sv
// Sorted chain of cells with the extreme value always in cell zero.
// Depends on rmth_pkg and rmth_cell.
`default_nettype none

module rmth_chain
    import rmth_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int FW     = 10,
    parameter bit IS_MAX = 1'b0
) (
    input  wire logic          i_clk,
    input  wire t_cell_cmd     i_cmd,
    input  wire logic [FW-1:0] i_fill,
    output t_value             o_top
);

    t_value w_val    [DEPTH];
    logic   w_before [DEPTH];

    assign o_top = w_val[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_prev_val;
        logic   w_prev_before;
        t_value w_next_val;

        if (g == 0) begin : g_head
            assign w_prev_val    = w_val[0];
            assign w_prev_before = 1'b0;
        end else begin : g_body
            assign w_prev_val    = w_val[g-1];
            assign w_prev_before = w_before[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_val = w_val[g];
        end else begin : g_link
            assign w_next_val = w_val[g+1];
        end

        rmth_cell #(
            .IDX    (g),
            .FW     (FW),
            .IS_MAX (IS_MAX)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (i_cmd),
            .i_fill        (i_fill),
            .i_prev_val    (w_prev_val),
            .i_prev_before (w_prev_before),
            .i_next_val    (w_next_val),
            .o_val         (w_val[g]),
            .o_before      (w_before[g])
        );
    end

endmodule

`default_nettype wire

>>> src/running_median_two_heaps_unit.sv
// Running median over a stream of signed 32-bit words, top level.
// Depends on rmth_pkg, rmth_chain and rmth_cell.
//
// Use: each word on the input stream (tdata = sample) is added to the held set,
// and one word comes out on the output stream for it: tdata holds twice the
// median (bits 32:0) and the count held (bits 43:33); tuser bit 0 flags a
// sample dropped because CAPACITY values are already held.
// The lower half sits in a descending chain of cells, the upper half in an
// ascending one, so both middle values are always in the first cells.
// Sequence: a dropped sample goes straight to the result state; a plain insert
// places the word in one chain; when a value crosses between halves, the top of
// one chain first moves to the other. Each chain takes one insert or shift per
// cycle; a crossing needs two updates. A new word is taken in the cycle after
// the previous result is loaded.
// Reset empties both halves and drops any pending output word.
// A stalled receiver holds the result in the output register; one more word
// is accepted and processed meanwhile, then the block waits for the slot.
`default_nettype none

module running_median_two_heaps_unit
    import rmth_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   i_s_axis_tdata,  // [31:0] sample
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // [32:0] median_doubled,
                                                        // [43:33] stored_count
    output logic [0:0]                 o_m_axis_tuser   // [0] dropped
);

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(CAPACITY + 1);

    t_state         r_state;
    t_state         n_state;
    logic [FW-1:0]  r_lo_fill;
    logic [FW-1:0]  n_lo_fill;
    logic [FW-1:0]  r_up_fill;
    logic [FW-1:0]  n_up_fill;
    t_value         r_sample;
    logic           r_even;
    logic           r_trade;
    logic           r_drop;

    logic           r_out_valid;
    t_median        r_out_median;
    logic [COUNT_W-1:0] r_out_count;
    logic           r_out_drop;

    t_cell_cmd      w_lo_cmd;
    t_cell_cmd      w_up_cmd;
    t_value         w_lo_top;
    t_value         w_up_top;
    logic [CW-1:0]  w_count;
    logic           w_accept;
    logic           w_drop;
    logic           w_even;
    logic           w_trade;
    logic           w_load;
    t_value         w_in;
    t_median        w_median;

    assign w_in     = i_s_axis_tdata;
    assign w_count  = CW'(r_lo_fill) + CW'(r_up_fill);
    assign w_drop   = w_count >= CW'(CAPACITY);
    assign w_even   = ~w_count[0];
    assign w_trade  = w_even ? ((r_lo_fill != '0) && (w_in < w_lo_top))
                             : ((r_up_fill != '0) && (w_in > w_up_top));
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = (r_state == ST_RESULT) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_median = '0;
        if (r_up_fill != '0) begin
            if (w_even && (r_lo_fill != '0)) begin
                w_median = t_median'(w_up_top) + t_median'(w_lo_top);
            end else begin
                w_median = {w_up_top, 1'b0};
            end
        end
    end

    rmth_chain #(
        .DEPTH  (DEPTH),
        .FW     (FW),
        .IS_MAX (1'b1)
    ) u_lower (
        .i_clk  (i_clk),
        .i_cmd  (w_lo_cmd),
        .i_fill (r_lo_fill),
        .o_top  (w_lo_top)
    );

    rmth_chain #(
        .DEPTH  (DEPTH),
        .FW     (FW),
        .IS_MAX (1'b0)
    ) u_upper (
        .i_clk  (i_clk),
        .i_cmd  (w_up_cmd),
        .i_fill (r_up_fill),
        .o_top  (w_up_top)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_drop) begin
                        n_state = ST_RESULT;
                    end else if (w_trade) begin
                        n_state = ST_SWAP;
                    end else begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_SWAP:   n_state = ST_PLACE;
            ST_PLACE:  n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_lo_cmd        = '{op: OP_NOP, value: r_sample};
        w_up_cmd        = '{op: OP_NOP, value: r_sample};
        n_lo_fill       = r_lo_fill;
        n_up_fill       = r_up_fill;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_SWAP: begin
                if (r_even) begin
                    w_up_cmd  = '{op: OP_INS, value: w_lo_top};
                    w_lo_cmd  = '{op: OP_POP, value: r_sample};
                    n_up_fill = r_up_fill + 1'b1;
                    n_lo_fill = r_lo_fill - 1'b1;
                end else begin
                    w_lo_cmd  = '{op: OP_INS, value: w_up_top};
                    w_up_cmd  = '{op: OP_POP, value: r_sample};
                    n_lo_fill = r_lo_fill + 1'b1;
                    n_up_fill = r_up_fill - 1'b1;
                end
            end
            ST_PLACE: begin
                if (r_even == r_trade) begin
                    w_lo_cmd  = '{op: OP_INS, value: r_sample};
                    n_lo_fill = r_lo_fill + 1'b1;
                end else begin
                    w_up_cmd  = '{op: OP_INS, value: r_sample};
                    n_up_fill = r_up_fill + 1'b1;
                end
            end
            ST_RESULT: o_s_axis_tready = 1'b0;
            default:   o_s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lo_fill   <= '0;
            r_up_fill   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lo_fill <= n_lo_fill;
            r_up_fill <= n_up_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= w_in;
            r_even   <= w_even;
            r_trade  <= w_trade;
            r_drop   <= w_drop;
        end
        if (w_load) begin
            r_out_median <= w_median;
            r_out_count  <= COUNT_W'(w_count);
            r_out_drop   <= r_drop;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {{(OUT_DATA_W - MEDIAN_W - COUNT_W){1'b0}},
                                r_out_count, r_out_median};
    assign o_m_axis_tuser[0] = r_out_drop;

    a_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |->
            ((r_up_fill == r_lo_fill) || (r_up_fill == r_lo_fill + 1'b1)))
        else $error("halves out of balance");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_drop) |-> (r_out_count == COUNT_W'(w_count)))
        else $error("dropped word with changing count");

endmodule

`default_nettype wire
